### hw/rtl/srec_pkg.sv
// Shared types and constants of the S-record stream loader.
// Used by srec_classify, srec_queue, srec_exec and srecord_stream_loader.
package srec_pkg;

	typedef enum logic [1:0] {
		CH_DIGIT,
		CH_START,
		CH_EOL,
		CH_BAD
	} char_class_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_COUNT,
		PH_ADDR,
		PH_DROP,
		PH_LOAD,
		PH_CSUM
	} phase_t;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_START    = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR    = 3'd2;
	localparam logic [2:0] ST_CSUM_ERR    = 3'd3;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
	localparam logic [2:0] ST_EOF         = 3'd5;

	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_AT = 8'h40;
	localparam logic [7:0] CHAR_7  = 8'h37;
	localparam logic [7:0] CHAR_0  = 8'h30;

	typedef struct packed {
		char_class_t cls;
		logic [7:0]  nib;
		logic [7:0]  typ;
	} item_t;

	function automatic logic [2:0] addr_len(input logic [3:0] rt);
		logic [2:0] n;
		unique case (rt)
			4'd0, 4'd1, 4'd5, 4'd9: n = 3'd2;
			4'd2, 4'd8:             n = 3'd3;
			4'd3, 4'd7:             n = 3'd4;
			default:                n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic is_start_type(input logic [3:0] rt);
		return (rt >= 4'd7) && (rt <= 4'd9);
	endfunction

endpackage

### hw/rtl/srecord_stream_loader.sv
// Top level of the S-record stream loader: classifier, queue and record engine.
// Depends on srec_pkg, srec_classify, srec_queue and srec_exec.
//
//   channel  handshake              word
//   in       in_valid / in_stall    char_in
//   out      out_valid / out_stall  status, write_valid, write_address,
//                                   write_data, start_address
//
// One character per cycle sustained while out_stall is low; each word is written into the
// queue when taken, then popped into the engine's output register.
// The record engine updates its state once per popped word.
// in_stall rises only when the two-entry queue is full.
// Reset clears the record state, the queue and the output valid.
module srecord_stream_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        write_valid,
	output logic [31:0] write_address,
	output logic [7:0]  write_data,
	output logic [31:0] start_address
);

	srec_pkg::item_t cls_item;
	srec_pkg::item_t head;
	logic            q_full;
	logic            head_valid;
	logic            pop;
	logic            push;

	assign push     = in_valid && !q_full;
	assign in_stall = q_full;

	srec_classify u_classify (
		.char_in (char_in),
		.item    (cls_item)
	);

	srec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (cls_item),
		.full       (q_full),
		.head_valid (head_valid),
		.dout       (head),
		.pop        (pop)
	);

	srec_exec u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_data    (write_data),
		.start_address (start_address)
	);

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_valid) |-> (status == srec_pkg::ST_OK))
		else $error("write word carries a non-ok status");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_valid) |-> (write_address == 32'd0 && write_data == 8'd0))
		else $error("idle write fields not zero");

	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop)
		else $error("engine advanced while output stalled");

	a_start_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(start_address))
		else $error("start address moved without a word");

endmodule

### hw/rtl/srec_classify.sv
// Front end: sorts each incoming character and decodes its digit values.
// Depends on srec_pkg.
module srec_classify (
	input  logic [7:0]     char_in,
	output srec_pkg::item_t item
);

	logic [7:0] c;

	assign c = char_in;

	always_comb begin
		priority if (c == srec_pkg::CHAR_S) begin
			item.cls = srec_pkg::CH_START;
		end else if (c == srec_pkg::CHAR_CR || c == srec_pkg::CHAR_LF) begin
			item.cls = srec_pkg::CH_EOL;
		end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h47 && c <= 8'h52) ||
			(c >= 8'h54 && c <= 8'h5a)) begin
			item.cls = srec_pkg::CH_BAD;
		end else begin
			item.cls = srec_pkg::CH_DIGIT;
		end
		item.nib = (c > srec_pkg::CHAR_AT) ? (c - srec_pkg::CHAR_7) : (c - srec_pkg::CHAR_0);
		item.typ = c - srec_pkg::CHAR_0;
	end

endmodule

### hw/rtl/srec_queue.sv
// Two-entry queue between the classifier and the record engine.
// Depends on srec_pkg.
module srec_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srec_pkg::item_t din,
	output logic            full,
	output logic            head_valid,
	output srec_pkg::item_t dout,
	input  logic            pop
);

	srec_pkg::item_t entry0_q, entry1_q;
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign dout       = rd_ptr_q ? entry1_q : entry0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_ptr_q) begin
			entry0_q <= din;
		end
		if (push && wr_ptr_q) begin
			entry1_q <= din;
		end
	end

endmodule

### hw/rtl/srec_exec.sv
// Back end: record state machine, checksum, address counter and output register.
// Depends on srec_pkg.
module srec_exec (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  srec_pkg::item_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      status,
	output logic            write_valid,
	output logic [31:0]     write_address,
	output logic [7:0]      write_data,
	output logic [31:0]     start_address
);

	srec_pkg::phase_t phase_q, phase_d;
	logic [3:0]  rt_q, rt_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  seen_q, seen_d;
	logic [2:0]  left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] la_q, la_d;
	logic [7:0]  hi_q, hi_d;
	logic        nsel_q, nsel_d;
	logic [31:0] start_q, start_d;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        wv_q;
	logic [31:0] wa_q;
	logic [7:0]  wd_q;

	logic [2:0]  st;
	logic        wv;
	logic [31:0] wa;
	logic [7:0]  wd;

	logic [7:0]  val;
	logic [7:0]  seen_inc;
	logic        done;
	logic [2:0]  left_dec;
	logic        typ_ok;
	logic        pair_done;
	logic [31:0] la_shift;

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign val       = {hi_q[3:0], 4'h0} + head.nib;
	assign seen_inc  = seen_q + 8'd1;
	assign done      = (seen_inc == (count_q - 8'd1));
	assign left_dec  = left_q - 3'd1;
	assign typ_ok    = (head.typ <= 8'd3) || (head.typ >= 8'd7 && head.typ <= 8'd9);
	assign pair_done = (head.cls == srec_pkg::CH_DIGIT) && nsel_q;
	assign la_shift  = {la_q[23:0], val};

	always_comb begin
		phase_d = phase_q;
		unique case (head.cls)
			srec_pkg::CH_START: phase_d = srec_pkg::PH_TYPE;
			srec_pkg::CH_EOL:   phase_d = srec_pkg::PH_IDLE;
			srec_pkg::CH_BAD:   phase_d = phase_q;
			srec_pkg::CH_DIGIT: begin
				if (phase_q == srec_pkg::PH_TYPE) begin
					phase_d = typ_ok ? srec_pkg::PH_COUNT : srec_pkg::PH_IDLE;
				end else if (pair_done) begin
					unique case (phase_q)
						srec_pkg::PH_COUNT: phase_d = srec_pkg::PH_ADDR;
						srec_pkg::PH_ADDR: begin
							if (left_dec == 3'd0) begin
								if (srec_pkg::is_start_type(rt_q) || done) begin
									phase_d = srec_pkg::PH_CSUM;
								end else if (rt_q == 4'd0) begin
									phase_d = srec_pkg::PH_DROP;
								end else begin
									phase_d = srec_pkg::PH_LOAD;
								end
							end else if (done) begin
								phase_d = srec_pkg::PH_CSUM;
							end
						end
						srec_pkg::PH_DROP, srec_pkg::PH_LOAD: begin
							if (done) begin
								phase_d = srec_pkg::PH_CSUM;
							end
						end
						srec_pkg::PH_CSUM: phase_d = srec_pkg::PH_IDLE;
						default:           phase_d = phase_q;
					endcase
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	always_comb begin
		rt_d    = rt_q;
		count_d = count_q;
		seen_d  = seen_q;
		left_d  = left_q;
		sum_d   = sum_q;
		la_d    = la_q;
		hi_d    = hi_q;
		nsel_d  = nsel_q;
		start_d = start_q;
		st      = srec_pkg::ST_OK;
		wv      = 1'b0;
		wa      = 32'd0;
		wd      = 8'd0;
		unique case (head.cls)
			srec_pkg::CH_START, srec_pkg::CH_EOL: nsel_d = 1'b0;
			srec_pkg::CH_BAD:                     st = srec_pkg::ST_BAD_CHAR;
			srec_pkg::CH_DIGIT: begin
				if (phase_q == srec_pkg::PH_IDLE) begin
					st = srec_pkg::ST_NO_START;
				end else if (phase_q == srec_pkg::PH_TYPE) begin
					if (typ_ok) begin
						rt_d  = head.typ[3:0];
						sum_d = 8'd0;
					end else begin
						st = srec_pkg::ST_UNSUPPORTED;
					end
				end else if (!nsel_q) begin
					hi_d   = head.nib;
					nsel_d = 1'b1;
				end else begin
					nsel_d = 1'b0;
					unique case (phase_q)
						srec_pkg::PH_COUNT: begin
							sum_d   = sum_q + val;
							count_d = val;
							seen_d  = 8'd0;
							left_d  = srec_pkg::addr_len(rt_q);
							la_d    = 32'd0;
						end
						srec_pkg::PH_ADDR: begin
							sum_d  = sum_q + val;
							seen_d = seen_inc;
							la_d   = la_shift;
							left_d = left_dec;
							if (left_dec == 3'd0 && srec_pkg::is_start_type(rt_q)) begin
								start_d = la_shift;
							end
						end
						srec_pkg::PH_DROP, srec_pkg::PH_LOAD: begin
							sum_d  = sum_q + val;
							seen_d = seen_inc;
							if (phase_q == srec_pkg::PH_LOAD) begin
								wv   = 1'b1;
								wa   = la_q;
								wd   = val;
								la_d = la_q + 32'd1;
							end
						end
						srec_pkg::PH_CSUM: begin
							if (~sum_q != val) begin
								st = srec_pkg::ST_CSUM_ERR;
							end else if (srec_pkg::is_start_type(rt_q)) begin
								st = srec_pkg::ST_EOF;
							end
						end
						default: st = srec_pkg::ST_OK;
					endcase
				end
			end
			default: st = srec_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= srec_pkg::PH_IDLE;
			rt_q        <= 4'd0;
			count_q     <= 8'd0;
			seen_q      <= 8'd0;
			left_q      <= 3'd0;
			sum_q       <= 8'd0;
			la_q        <= 32'd0;
			hi_q        <= 8'd0;
			nsel_q      <= 1'b0;
			start_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				rt_q        <= rt_d;
				count_q     <= count_d;
				seen_q      <= seen_d;
				left_q      <= left_d;
				sum_q       <= sum_d;
				la_q        <= la_d;
				hi_q        <= hi_d;
				nsel_q      <= nsel_d;
				start_q     <= start_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= st;
			wv_q     <= wv;
			wa_q     <= wa;
			wd_q     <= wd;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign write_valid   = wv_q;
	assign write_address = wa_q;
	assign write_data    = wd_q;
	assign start_address = start_q;

endmodule
